// File: rtl/gn3d_pkg.sv
// Shared types and constants for the 3D gradient noise unit.
package gn3d_pkg;

  localparam int TableSize   = 256;
  localparam int IdxW        = $clog2(TableSize);
  localparam int ByteW       = 8;
  localparam int CoordW      = 32;
  localparam int FracBitsDef = 16;
  localparam int NoiseW      = 18;
  localparam int NoiseMax    = 131071;
  localparam int NoiseMin    = -131072;
  localparam int HashN       = 8;
  localparam int Latency     = 8;

  // fade polynomial 6t^5 - 15t^4 + 10t^3
  localparam int FadeMul = 6;
  localparam int FadeSub = 15;
  localparam int FadeAdd = 10;

  // gradient selection codes
  localparam int GradSplitU = 8;
  localparam int GradSplitV = 4;
  localparam int GradAltA   = 12;
  localparam int GradAltB   = 14;

  typedef enum logic [1:0] {
    MODE_LOAD    = 2'd0,
    MODE_EVAL_3D = 2'd1,
    MODE_EVAL_2D = 2'd2
  } mode_e;

  typedef struct packed {
    logic  vld;
    mode_e mode;
  } ctl_t;

endpackage

// File: rtl/gn3d_ram.sv
// Permutation table copy: one write port, two registered read ports.
module gn3d_ram (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [gn3d_pkg::IdxW-1:0]  waddr_i,
  input  logic [gn3d_pkg::ByteW-1:0] wdata_i,
  input  logic [gn3d_pkg::IdxW-1:0]  raddr_a_i,
  input  logic [gn3d_pkg::IdxW-1:0]  raddr_b_i,
  output logic [gn3d_pkg::ByteW-1:0] rdata_a_o,
  output logic [gn3d_pkg::ByteW-1:0] rdata_b_o
);
  import gn3d_pkg::*;

  logic [ByteW-1:0] mem_q [TableSize];
  logic [ByteW-1:0] rdata_a_q, rdata_b_q;

  // write one byte, read two
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// File: rtl/gn3d_fade.sv
// Four-stage quintic fade pipeline, one multiplier per stage.
module gn3d_fade #(
  parameter int FracBits = gn3d_pkg::FracBitsDef
) (
  input  logic                       clk_i,
  input  logic [FracBits-1:0]        frac_i,
  output logic signed [FracBits+5:0] fade_o
);
  import gn3d_pkg::*;

  localparam int FW = FracBits + 6;
  localparam int PW = FW + FracBits + 1;
  localparam logic signed [FW-1:0] One = FW'(1) << FracBits;

  logic signed [PW-1:0] m1_d, m1_q, m2_d, m2_q, m3_d, m3_q, m4_d, m4_q;
  logic [FracBits-1:0]  f1_q, f2_q, f3_q;
  logic signed [PW-1:0] f0_s, f1_s, f2_s, f3_s;
  logic signed [FW-1:0] b1, b2, b3;

  // widen fractions
  assign f0_s = $signed(PW'(frac_i));
  assign f1_s = $signed(PW'(f1_q));
  assign f2_s = $signed(PW'(f2_q));
  assign f3_s = $signed(PW'(f3_q));

  // one multiply per stage
  always_comb begin
    m1_d = (PW'(FadeMul) * f0_s - PW'(FadeSub) * PW'(One)) * f0_s;
    b1   = FW'(m1_q >>> FracBits) + FW'(FadeAdd) * One;
    m2_d = PW'(b1) * f1_s;
    b2   = FW'(m2_q >>> FracBits);
    m3_d = PW'(b2) * f2_s;
    b3   = FW'(m3_q >>> FracBits);
    m4_d = PW'(b3) * f3_s;
  end

  // advance the stages
  always_ff @(posedge clk_i) begin
    m1_q <= m1_d;
    f1_q <= frac_i;
    m2_q <= m2_d;
    f2_q <= f1_q;
    m3_q <= m3_d;
    f3_q <= f2_q;
    m4_q <= m4_d;
  end

  assign fade_o = FW'(m4_q >>> FracBits);

endmodule

// File: rtl/gn3d_hash.sv
// Corner hashing through three levels of table copies, four stages.
module gn3d_hash (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  gn3d_pkg::ctl_t             ctl_i,
  input  logic [gn3d_pkg::IdxW-1:0]  cell_x_i,
  input  logic [gn3d_pkg::IdxW-1:0]  cell_y_i,
  input  logic [gn3d_pkg::IdxW-1:0]  cell_z_i,
  input  logic [gn3d_pkg::IdxW-1:0]  entry_index_i,
  input  logic [gn3d_pkg::ByteW-1:0] entry_value_i,
  output logic [gn3d_pkg::ByteW-1:0] hash_o [gn3d_pkg::HashN],
  output gn3d_pkg::ctl_t             ctl_o
);
  import gn3d_pkg::*;

  ctl_t             ctl_q [4];
  logic [IdxW-1:0]  cy_q, cz0_q, cz1_q;
  logic [IdxW-1:0]  idx_q [2];
  logic [ByteW-1:0] val_q [2];
  logic [ByteW-1:0] h2d_q [4];
  logic [ByteW-1:0] hash_q [HashN];

  logic             we0, we1, we2;
  logic [IdxW-1:0]  cx1, ha, ha1, hb, hb1;
  logic [ByteW-1:0] t0_a, t0_b;
  logic [ByteW-1:0] t1 [4];
  logic [IdxW-1:0]  s2 [4];
  logic [IdxW-1:0]  s2p [4];
  logic [ByteW-1:0] t2_lo [4];
  logic [ByteW-1:0] t2_hi [4];

  // each copy is written when the load word reaches its read stage
  assign we0 = ctl_i.vld && (ctl_i.mode == MODE_LOAD);
  assign we1 = ctl_q[0].vld && (ctl_q[0].mode == MODE_LOAD);
  assign we2 = ctl_q[1].vld && (ctl_q[1].mode == MODE_LOAD);

  // level 0: perm[x], perm[x+1]
  assign cx1 = cell_x_i + IdxW'(1);

  gn3d_ram u_t0 (
    .clk_i, .we_i(we0), .waddr_i(entry_index_i), .wdata_i(entry_value_i),
    .raddr_a_i(cell_x_i), .raddr_b_i(cx1), .rdata_a_o(t0_a), .rdata_b_o(t0_b)
  );

  // level 1: A = perm[x]+y, B = perm[x+1]+y
  assign ha  = t0_a + cy_q;
  assign hb  = t0_b + cy_q;
  assign ha1 = ha + IdxW'(1);
  assign hb1 = hb + IdxW'(1);

  gn3d_ram u_t1a (
    .clk_i, .we_i(we1), .waddr_i(idx_q[0]), .wdata_i(val_q[0]),
    .raddr_a_i(ha), .raddr_b_i(ha1), .rdata_a_o(t1[0]), .rdata_b_o(t1[1])
  );

  gn3d_ram u_t1b (
    .clk_i, .we_i(we1), .waddr_i(idx_q[0]), .wdata_i(val_q[0]),
    .raddr_a_i(hb), .raddr_b_i(hb1), .rdata_a_o(t1[2]), .rdata_b_o(t1[3])
  );

  // level 2: AA, AB, BA, BB and their +1 neighbors
  for (genvar k = 0; k < 4; k++) begin : g_t2
    assign s2[k]  = t1[k] + cz1_q;
    assign s2p[k] = s2[k] + IdxW'(1);

    gn3d_ram u_t2 (
      .clk_i, .we_i(we2), .waddr_i(idx_q[1]), .wdata_i(val_q[1]),
      .raddr_a_i(s2[k]), .raddr_b_i(s2p[k]), .rdata_a_o(t2_lo[k]), .rdata_b_o(t2_hi[k])
    );
  end

  // control pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        ctl_q[i] <= '0;
      end
    end else begin
      ctl_q[0] <= ctl_i;
      for (int i = 1; i < 4; i++) begin
        ctl_q[i] <= ctl_q[i-1];
      end
    end
  end

  // payload pipeline; order hashes by lerp pair
  always_ff @(posedge clk_i) begin
    cy_q     <= cell_y_i;
    cz0_q    <= cell_z_i;
    cz1_q    <= cz0_q;
    idx_q[0] <= entry_index_i;
    val_q[0] <= entry_value_i;
    idx_q[1] <= idx_q[0];
    val_q[1] <= val_q[0];
    for (int i = 0; i < 4; i++) begin
      h2d_q[i] <= t1[i];
    end
    hash_q[4] <= t2_hi[0];
    hash_q[5] <= t2_hi[2];
    hash_q[6] <= t2_hi[1];
    hash_q[7] <= t2_hi[3];
    if (ctl_q[2].mode == MODE_EVAL_2D) begin
      hash_q[0] <= h2d_q[0];
      hash_q[1] <= h2d_q[2];
      hash_q[2] <= h2d_q[1];
      hash_q[3] <= h2d_q[3];
    end else begin
      hash_q[0] <= t2_lo[0];
      hash_q[1] <= t2_lo[2];
      hash_q[2] <= t2_lo[1];
      hash_q[3] <= t2_lo[3];
    end
  end

  assign hash_o = hash_q;
  assign ctl_o  = ctl_q[3];

endmodule

// File: rtl/gn3d_blend.sv
// Gradient dot products and three lerp levels, four stages to the output.
module gn3d_blend #(
  parameter int FracBits = gn3d_pkg::FracBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  gn3d_pkg::ctl_t                    ctl_i,
  input  logic [FracBits-1:0]               frac_x_i,
  input  logic [FracBits-1:0]               frac_y_i,
  input  logic [FracBits-1:0]               frac_z_i,
  input  logic signed [FracBits+5:0]        fade_u_i,
  input  logic signed [FracBits+5:0]        fade_v_i,
  input  logic signed [FracBits+5:0]        fade_w_i,
  input  logic [gn3d_pkg::ByteW-1:0]        hash_i [gn3d_pkg::HashN],
  output logic signed [gn3d_pkg::NoiseW-1:0] noise_o,
  output logic                              valid_o
);
  import gn3d_pkg::*;

  localparam int VW  = FracBits + 6;
  localparam int MW  = 2 * VW;
  localparam int RW  = VW + 16;
  localparam int ShR = (FracBits > 16) ? FracBits - 16 : 0;
  localparam int ShL = (FracBits > 16) ? 0 : 16 - FracBits;
  localparam logic signed [VW-1:0] One   = VW'(1) << FracBits;
  localparam logic signed [RW-1:0] SatHi = RW'(NoiseMax);
  localparam logic signed [RW-1:0] SatLo = RW'(NoiseMin);

  function automatic logic signed [VW-1:0] grad(input logic [3:0] h,
                                                 input logic signed [VW-1:0] x,
                                                 input logic signed [VW-1:0] y,
                                                 input logic signed [VW-1:0] z);
    logic signed [VW-1:0] a, b;
    a = (h < 4'(GradSplitU)) ? x : y;
    b = (h < 4'(GradSplitV)) ? y :
        ((h == 4'(GradAltA) || h == 4'(GradAltB)) ? x : z);
    if (h[0]) a = -a;
    if (h[1]) b = -b;
    return a + b;
  endfunction

  ctl_t                 c_q [3];
  logic signed [VW-1:0] v1_q, w1_q, w2_q;
  logic signed [VW-1:0] g0_d [4];
  logic signed [VW-1:0] g0_q [4];
  logic signed [MW-1:0] pm1_d [4];
  logic signed [MW-1:0] pm1_q [4];
  logic signed [VW-1:0] b2_d [2];
  logic signed [VW-1:0] b2_q [2];
  logic signed [MW-1:0] pm2_d [2];
  logic signed [MW-1:0] pm2_q [2];
  logic signed [VW-1:0] b3_d, b3_q;
  logic signed [MW-1:0] pm3_d, pm3_q;
  logic signed [NoiseW-1:0] noise_d, noise_q;
  logic                 valid_q;

  logic signed [VW-1:0] x0, x1, y0, y1, z0, z1, zf;
  logic signed [VW-1:0] q [4];
  logic signed [VW-1:0] r [2];
  logic signed [VW-1:0] res;
  logic signed [RW-1:0] ext, sc;

  // corner offsets; 2D takes z = 0
  always_comb begin
    x0 = $signed(VW'(frac_x_i));
    x1 = x0 - One;
    y0 = $signed(VW'(frac_y_i));
    y1 = y0 - One;
    zf = $signed(VW'(frac_z_i));
    z0 = (ctl_i.mode == MODE_EVAL_2D) ? '0 : zf;
    z1 = zf - One;
  end

  // gradients and x lerp products
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      logic signed [VW-1:0] yo, zo, ga, gb;
      yo = ((j & 1) != 0) ? y1 : y0;
      zo = ((j & 2) != 0) ? z1 : z0;
      ga = grad(hash_i[2*j][3:0], x0, yo, zo);
      gb = grad(hash_i[2*j+1][3:0], x1, yo, zo);
      g0_d[j]  = ga;
      pm1_d[j] = MW'(fade_u_i) * MW'(gb - ga);
    end
  end

  // finish x lerps, y lerp products
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      q[j] = g0_q[j] + VW'(pm1_q[j] >>> FracBits);
    end
    for (int k = 0; k < 2; k++) begin
      b2_d[k]  = q[2*k];
      pm2_d[k] = MW'(v1_q) * MW'(q[2*k+1] - q[2*k]);
    end
  end

  // finish y lerps, z lerp product
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      r[k] = b2_q[k] + VW'(pm2_q[k] >>> FracBits);
    end
    b3_d  = r[0];
    pm3_d = MW'(w2_q) * MW'(r[1] - r[0]);
  end

  // final lerp (3D only), rescale to 16 fraction bits, saturate
  always_comb begin
    res = (c_q[2].mode == MODE_EVAL_2D) ? b3_q : b3_q + VW'(pm3_q >>> FracBits);
    ext = RW'(res);
    sc  = (ext >>> ShR) <<< ShL;
    if (sc > SatHi) begin
      noise_d = NoiseW'(SatHi);
    end else if (sc < SatLo) begin
      noise_d = NoiseW'(SatLo);
    end else begin
      noise_d = NoiseW'(sc);
    end
  end

  // control stages and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        c_q[i] <= '0;
      end
      valid_q <= 1'b0;
    end else begin
      c_q[0]  <= ctl_i;
      c_q[1]  <= c_q[0];
      c_q[2]  <= c_q[1];
      valid_q <= c_q[2].vld &&
                 (c_q[2].mode == MODE_EVAL_3D || c_q[2].mode == MODE_EVAL_2D);
    end
  end

  // data stages
  always_ff @(posedge clk_i) begin
    v1_q <= fade_v_i;
    w1_q <= fade_w_i;
    w2_q <= w1_q;
    g0_q  <= g0_d;
    pm1_q <= pm1_d;
    b2_q  <= b2_d;
    pm2_q <= pm2_d;
    b3_q  <= b3_d;
    pm3_q <= pm3_d;
    noise_q <= noise_d;
  end

  assign noise_o = noise_q;
  assign valid_o = valid_q;

endmodule

// File: rtl/gradient_noise_3d_unit.sv
// Top level of the 3D/2D improved gradient noise unit.
//
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------------------------
//  command | start_i, busy_o    | mode_i, coord_x/y/z_i, entry_index_i, entry_value_i
//  result  | valid_o (strobe)   | noise_value_o
//
// One word enters every cycle; busy_o stays low. An evaluation gives its
// result after four stages of table lookups alongside the four fade
// multiplies, then gradients and three lerp levels, each with its own
// multiply stage. Loads write each table copy as the word passes its
// read stage. Reset clears the valid pipeline only; table contents are
// undefined until loaded. The receiver cannot stall, so nothing ever holds.
module gradient_noise_3d_unit #(
  parameter int FracBits = gn3d_pkg::FracBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [1:0]                          mode_i,
  input  logic signed [gn3d_pkg::CoordW-1:0]  coord_x_i,
  input  logic signed [gn3d_pkg::CoordW-1:0]  coord_y_i,
  input  logic signed [gn3d_pkg::CoordW-1:0]  coord_z_i,
  input  logic [gn3d_pkg::IdxW-1:0]           entry_index_i,
  input  logic [gn3d_pkg::ByteW-1:0]          entry_value_i,
  output logic signed [gn3d_pkg::NoiseW-1:0]  noise_value_o,
  output logic                                valid_o
);
  import gn3d_pkg::*;

  localparam int FW = FracBits + 6;

  ctl_t                ctl_in, ctl_hash;
  logic [ByteW-1:0]    hash [HashN];
  logic signed [FW-1:0] fade_u, fade_v, fade_w;
  logic [FracBits-1:0] fx_q [4];
  logic [FracBits-1:0] fy_q [4];
  logic [FracBits-1:0] fz_q [4];

  // accept a word whenever start is high
  assign busy_o      = 1'b0;
  assign ctl_in.vld  = start_i && !busy_o;
  assign ctl_in.mode = mode_e'(mode_i);

  gn3d_hash u_hash (
    .clk_i, .rst_ni, .ctl_i(ctl_in),
    .cell_x_i(coord_x_i[FracBits+IdxW-1:FracBits]),
    .cell_y_i(coord_y_i[FracBits+IdxW-1:FracBits]),
    .cell_z_i(coord_z_i[FracBits+IdxW-1:FracBits]),
    .entry_index_i, .entry_value_i,
    .hash_o(hash), .ctl_o(ctl_hash)
  );

  gn3d_fade #(.FracBits(FracBits)) u_fade_x (
    .clk_i, .frac_i(coord_x_i[FracBits-1:0]), .fade_o(fade_u)
  );

  gn3d_fade #(.FracBits(FracBits)) u_fade_y (
    .clk_i, .frac_i(coord_y_i[FracBits-1:0]), .fade_o(fade_v)
  );

  gn3d_fade #(.FracBits(FracBits)) u_fade_z (
    .clk_i, .frac_i(coord_z_i[FracBits-1:0]), .fade_o(fade_w)
  );

  // delay fractions to the gradient stage
  always_ff @(posedge clk_i) begin
    fx_q[0] <= coord_x_i[FracBits-1:0];
    fy_q[0] <= coord_y_i[FracBits-1:0];
    fz_q[0] <= coord_z_i[FracBits-1:0];
    for (int i = 1; i < 4; i++) begin
      fx_q[i] <= fx_q[i-1];
      fy_q[i] <= fy_q[i-1];
      fz_q[i] <= fz_q[i-1];
    end
  end

  gn3d_blend #(.FracBits(FracBits)) u_blend (
    .clk_i, .rst_ni, .ctl_i(ctl_hash),
    .frac_x_i(fx_q[3]), .frac_y_i(fy_q[3]), .frac_z_i(fz_q[3]),
    .fade_u_i(fade_u), .fade_v_i(fade_v), .fade_w_i(fade_w),
    .hash_i(hash), .noise_o(noise_value_o), .valid_o
  );

`ifndef SYNTHESIS
  // a strobe traces back to an accepted evaluation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i && (mode_i == MODE_EVAL_3D || mode_i == MODE_EVAL_2D),
                      Latency))
    else $error("result strobe without an evaluation");

  // every accepted evaluation gives a strobe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && (mode_i == MODE_EVAL_3D || mode_i == MODE_EVAL_2D)) |-> ##Latency valid_o)
    else $error("evaluation lost in pipeline");

  // a load never gives a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && mode_i == MODE_LOAD) |-> ##Latency !valid_o)
    else $error("load produced a result");
`endif

endmodule
